// File: hw/rtl/pfta_pkg.sv
// Shared types and constants for the page frame translation block.
`default_nettype none

package pfta_pkg;

	// Fixed field widths of the request and response items.
	localparam int ADDR_W   = 16;
	localparam int LIMIT_W  = 17;
	localparam int STATUS_W = 2;
	localparam int PAGE_O_W = 6;
	localparam int OFF_O_W  = 10;
	localparam int FRAME_O_W = 2;
	localparam int PHYS_O_W = 12;
	localparam int COUNT_W  = 16;

	// Configuration port.
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam logic [APB_ADDR_W-1:0] REG_VIRTUAL_LIMIT = 3'd0;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 17'd8192;

	// Result status codes.
	localparam logic [STATUS_W-1:0] ST_HIT  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_LOAD = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;
	localparam logic [STATUS_W-1:0] ST_OOB  = 2'd3;

	localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

	// Control flags of a lookup probe walking the row of frame cells.
	typedef struct packed {
		logic live;  // a probe occupies this stage
		logic oob;   // address was at or above the limit
		logic done;  // a cell has already resolved the lookup
		logic hit;   // resolved by a matching entry
	} pfta_probe_t;

	// Saturating increment of an event counter.
	function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] c);
		sat_inc = (c == COUNT_MAX) ? c : c + COUNT_W'(1);
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/pfta_if.sv
// Request and response stream interfaces of the page frame translation block.
`default_nettype none

interface pfta_req_if import pfta_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [ADDR_W-1:0] vaddr;

	modport source (output valid, output vaddr, input ready);
	modport sink (input valid, input vaddr, output ready);
endinterface

interface pfta_rsp_if import pfta_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [STATUS_W-1:0]  status;
	logic [PAGE_O_W-1:0]  page_number;
	logic [OFF_O_W-1:0]   byte_offset;
	logic [FRAME_O_W-1:0] frame_number;
	logic [PHYS_O_W-1:0]  physical_address;
	logic [COUNT_W-1:0]   hit_total;
	logic [COUNT_W-1:0]   fault_total;

	modport source (
		output valid, output status, output page_number, output byte_offset,
		output frame_number, output physical_address, output hit_total,
		output fault_total, input ready
	);
	modport sink (
		input valid, input status, input page_number, input byte_offset,
		input frame_number, input physical_address, input hit_total,
		input fault_total, output ready
	);
endinterface

`default_nettype wire

// File: hw/rtl/pfta_cell.sv
// One frame table entry that inspects a passing probe and hands it on.
`default_nettype none

module pfta_cell import pfta_pkg::*; #(
	parameter int IDX     = 0,
	parameter int PAGE_W  = 6,
	parameter int FRAME_W = 2
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire pfta_probe_t        probe_in,
	input  wire logic [PAGE_W-1:0]  page_in,
	input  wire logic [FRAME_W-1:0] frame_in,
	output pfta_probe_t             probe_out,
	output logic [PAGE_W-1:0]       page_out,
	output logic [FRAME_W-1:0]      frame_out,
	output logic                    entry_valid
);

	logic               valid_q;
	logic [PAGE_W-1:0]  page_q;
	pfta_probe_t        probe_q;
	logic [PAGE_W-1:0]  page_out_q;
	logic [FRAME_W-1:0] frame_out_q;
	logic               searching;
	logic               match;
	logic               claim;
	pfta_probe_t        probe_nxt;

	// An unresolved probe hits a matching entry or claims this entry if empty.
	// Entries fill from the low end, so an empty entry ends the search.
	always_comb begin
		searching      = probe_in.live && !probe_in.done;
		match          = searching && valid_q && (page_q == page_in);
		claim          = searching && !valid_q;
		probe_nxt      = probe_in;
		probe_nxt.done = probe_in.done | match | claim;
		probe_nxt.hit  = probe_in.hit | match;
	end

	// Entry state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (claim) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (claim) begin
			page_q <= page_in;
		end
	end

	// Probe hand-off to the next cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			probe_q <= '0;
		end else begin
			probe_q <= probe_nxt;
		end
	end

	always_ff @(posedge clk) begin
		page_out_q  <= page_in;
		frame_out_q <= (match || claim) ? FRAME_W'(IDX) : frame_in;
	end

	assign probe_out   = probe_q;
	assign page_out    = page_out_q;
	assign frame_out   = frame_out_q;
	assign entry_valid = valid_q;

endmodule

`default_nettype wire

// File: hw/rtl/pfta_regs.sv
// Configuration register file with an APB-style write and read port.
`default_nettype none

module pfta_regs import pfta_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0]      prdata,
	output logic                       pready,
	output logic [LIMIT_W-1:0]         virtual_limit
);

	logic [LIMIT_W-1:0] limit_q;
	logic               wr_en;

	// A write completes in the access phase; the port never waits.
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (wr_en && (paddr == REG_VIRTUAL_LIMIT)) begin
			limit_q <= pwdata[LIMIT_W-1:0];
		end
	end

	// Read decode; unmapped addresses read as zero.
	always_comb begin
		case (paddr)
			REG_VIRTUAL_LIMIT: prdata = APB_DATA_W'(limit_q);
			default:           prdata = '0;
		endcase
	end

	assign virtual_limit = limit_q;

endmodule

`default_nettype wire

// File: hw/rtl/page_frame_translate_alloc.sv
// Top level: demand-paging address translation over a row of frame cells.
// The lookup probe of an accepted address walks the row of frame cells; the block takes one
// item at a time: the probe walks the row one cell per cycle, and the next item enters after
// it leaves the row and the result buffer is empty or passing its result on.
// A finished result waits in a buffer and an output register, apart from the row.
// Reset empties all frames, zeroes both counters and sets the limit to 8192.
`default_nettype none

module page_frame_translate_alloc import pfta_pkg::*; #(
	parameter int OFFSET_BITS = 10,
	parameter int FRAME_COUNT = 4
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	pfta_req_if.sink                   req,
	pfta_rsp_if.source                 rsp,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0]      prdata,
	output logic                       pready
);

	localparam int PAGE_W  = (OFFSET_BITS >= ADDR_W) ? 1 : ADDR_W - OFFSET_BITS;
	localparam int FRAME_W = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;

	logic [LIMIT_W-1:0] virtual_limit;

	pfta_regs u_regs (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.virtual_limit (virtual_limit)
	);

	// Handshake and intake.
	logic                   busy_q;
	logic                   buf_valid_q;
	logic                   rsp_valid_q;
	logic                   rsp_load;
	logic                   accept;
	logic                   in_bounds;
	logic [31:0]            addr_ext;
	logic [OFFSET_BITS-1:0] offset_q;

	assign rsp_load  = buf_valid_q && (!rsp_valid_q || rsp.ready);
	assign req.ready = !busy_q && (!buf_valid_q || rsp_load);
	assign accept    = req.valid && req.ready;
	assign in_bounds = ({1'b0, req.vaddr} < virtual_limit);
	assign addr_ext  = 32'(req.vaddr);

	always_ff @(posedge clk) begin
		if (accept) begin
			offset_q <= addr_ext[OFFSET_BITS-1:0];
		end
	end

	// Row of frame cells; stage 0 is the probe formed from the accepted request.
	pfta_probe_t        probe_c [FRAME_COUNT+1];
	logic [PAGE_W-1:0]  page_c  [FRAME_COUNT+1];
	logic [FRAME_W-1:0] frame_c [FRAME_COUNT+1];
	logic [FRAME_COUNT-1:0] valid_vec;
	logic [FRAME_COUNT-1:0] live_vec;
	logic [31:0]            page_shift;

	assign page_shift = addr_ext >> OFFSET_BITS;

	always_comb begin
		probe_c[0].live = accept;
		probe_c[0].oob  = !in_bounds;
		probe_c[0].done = !in_bounds;
		probe_c[0].hit  = 1'b0;
		page_c[0]       = page_shift[PAGE_W-1:0];
		frame_c[0]      = '0;
	end

	for (genvar g = 0; g < FRAME_COUNT; g++) begin : g_cell
		pfta_cell #(
			.IDX     (g),
			.PAGE_W  (PAGE_W),
			.FRAME_W (FRAME_W)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.probe_in    (probe_c[g]),
			.page_in     (page_c[g]),
			.frame_in    (frame_c[g]),
			.probe_out   (probe_c[g+1]),
			.page_out    (page_c[g+1]),
			.frame_out   (frame_c[g+1]),
			.entry_valid (valid_vec[g])
		);
		assign live_vec[g] = probe_c[g+1].live;
	end

	// Resolve the probe leaving the row into result fields.
	pfta_probe_t          tail;
	logic [STATUS_W-1:0]  status_d;
	logic [31:0]          page_ext;
	logic [31:0]          offset_ext;
	logic [31:0]          frame_ext;
	logic [31:0]          phys_ext;
	logic [PAGE_O_W-1:0]  page_d;
	logic [OFF_O_W-1:0]   offset_d;
	logic [FRAME_O_W-1:0] frame_d;
	logic [PHYS_O_W-1:0]  phys_d;
	logic [COUNT_W-1:0]   hit_q;
	logic [COUNT_W-1:0]   fault_q;
	logic [COUNT_W-1:0]   hit_d;
	logic [COUNT_W-1:0]   fault_d;

	always_comb begin
		tail       = probe_c[FRAME_COUNT];
		page_ext   = 32'(page_c[FRAME_COUNT]);
		offset_ext = 32'(offset_q);
		frame_ext  = 32'(frame_c[FRAME_COUNT]);
		phys_ext   = (frame_ext << OFFSET_BITS) + offset_ext;
		hit_d      = hit_q;
		fault_d    = fault_q;
		if (tail.oob) begin
			status_d = ST_OOB;
		end else if (tail.hit) begin
			status_d = ST_HIT;
			hit_d    = sat_inc(hit_q);
		end else if (tail.done) begin
			status_d = ST_LOAD;
			fault_d  = sat_inc(fault_q);
		end else begin
			status_d = ST_FULL;
			fault_d  = sat_inc(fault_q);
		end
		page_d   = tail.oob ? '0 : page_ext[PAGE_O_W-1:0];
		offset_d = tail.oob ? '0 : offset_ext[OFF_O_W-1:0];
		if ((status_d == ST_HIT) || (status_d == ST_LOAD)) begin
			frame_d = frame_ext[FRAME_O_W-1:0];
			phys_d  = phys_ext[PHYS_O_W-1:0];
		end else begin
			frame_d = '0;
			phys_d  = '0;
		end
	end

	// Control: busy while a probe is in the row, then the result sits in the buffer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			buf_valid_q <= 1'b0;
			rsp_valid_q <= 1'b0;
			hit_q       <= '0;
			fault_q     <= '0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
			end else if (tail.live) begin
				busy_q <= 1'b0;
			end
			if (tail.live) begin
				buf_valid_q <= 1'b1;
				hit_q       <= hit_d;
				fault_q     <= fault_d;
			end else if (rsp_load) begin
				buf_valid_q <= 1'b0;
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Result buffer and output register payload.
	logic [STATUS_W-1:0]  buf_status_q, rsp_status_q;
	logic [PAGE_O_W-1:0]  buf_page_q, rsp_page_q;
	logic [OFF_O_W-1:0]   buf_offset_q, rsp_offset_q;
	logic [FRAME_O_W-1:0] buf_frame_q, rsp_frame_q;
	logic [PHYS_O_W-1:0]  buf_phys_q, rsp_phys_q;
	logic [COUNT_W-1:0]   buf_hit_q, rsp_hit_q;
	logic [COUNT_W-1:0]   buf_fault_q, rsp_fault_q;

	always_ff @(posedge clk) begin
		if (tail.live) begin
			buf_status_q <= status_d;
			buf_page_q   <= page_d;
			buf_offset_q <= offset_d;
			buf_frame_q  <= frame_d;
			buf_phys_q   <= phys_d;
			buf_hit_q    <= hit_d;
			buf_fault_q  <= fault_d;
		end
		if (rsp_load) begin
			rsp_status_q <= buf_status_q;
			rsp_page_q   <= buf_page_q;
			rsp_offset_q <= buf_offset_q;
			rsp_frame_q  <= buf_frame_q;
			rsp_phys_q   <= buf_phys_q;
			rsp_hit_q    <= buf_hit_q;
			rsp_fault_q  <= buf_fault_q;
		end
	end

	assign rsp.valid            = rsp_valid_q;
	assign rsp.status           = rsp_status_q;
	assign rsp.page_number      = rsp_page_q;
	assign rsp.byte_offset      = rsp_offset_q;
	assign rsp.frame_number     = rsp_frame_q;
	assign rsp.physical_address = rsp_phys_q;
	assign rsp.hit_total        = rsp_hit_q;
	assign rsp.fault_total      = rsp_fault_q;

	// Occupied frames always form a contiguous run from frame zero.
	a_frames_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		((valid_vec + FRAME_COUNT'(1)) & valid_vec) == '0)
		else $error("occupied frames are not contiguous");

	// At most one probe walks the row at a time.
	a_one_probe: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(live_vec))
		else $error("more than one probe in the frame row");

	// A probe in the row and a buffered result never coexist.
	a_busy_buf: assert property (@(posedge clk) disable iff (!arst_n)
		!(busy_q && buf_valid_q))
		else $error("busy with a result still buffered");

	// An accepted request enters the first cell on the next cycle.
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> probe_c[1].live)
		else $error("accepted request did not enter the frame row");

	// The hit counter never decreases.
	a_hit_mono: assert property (@(posedge clk) disable iff (!arst_n)
		hit_q >= $past(hit_q))
		else $error("hit counter decreased");

endmodule

`default_nettype wire

// File: tb/pfta_check_pkg.sv
// Scoreboard class that predicts and checks page frame translation results.
`timescale 1ns / 1ps

package pfta_check_pkg;
	import pfta_pkg::*;

	localparam int FRAMES       = 4;
	localparam int OFFSET_W     = 10;
	localparam int REPORT_LIMIT = 10;

	// One translation result, field for field as the response channel carries it.
	typedef struct packed {
		logic [STATUS_W-1:0]  status;
		logic [PAGE_O_W-1:0]  page_number;
		logic [OFF_O_W-1:0]   byte_offset;
		logic [FRAME_O_W-1:0] frame_number;
		logic [PHYS_O_W-1:0]  physical_address;
		logic [COUNT_W-1:0]   hit_total;
		logic [COUNT_W-1:0]   fault_total;
	} pfta_result_t;

	class pfta_scoreboard;
		logic [LIMIT_W-1:0]  limit;
		logic                frame_used [FRAMES];
		logic [PAGE_O_W-1:0] frame_page [FRAMES];
		logic [COUNT_W-1:0]  hit_count;
		logic [COUNT_W-1:0]  fault_count;
		pfta_result_t        pending [$];
		int unsigned         failures;

		function new();
			limit = LIMIT_RESET;
			foreach (frame_used[i]) begin
				frame_used[i] = 1'b0;
				frame_page[i] = '0;
			end
			hit_count = '0;
			fault_count = '0;
			failures = 0;
		endfunction

		// A configuration write keeps only the low bits of the data word.
		function void set_limit(input logic [APB_DATA_W-1:0] value);
			limit = value[LIMIT_W-1:0];
		endfunction

		// Page held by a loaded frame, searching upward from the given slot.
		function logic [PAGE_O_W-1:0] resident_page(input int start);
			int slot;
			resident_page = '0;
			for (int i = FRAMES - 1; i >= 0; i--) begin
				slot = (start + i) % FRAMES;
				if (frame_used[slot])
					resident_page = frame_page[slot];
			end
		endfunction

		// Translate one accepted address and queue the result it must produce.
		function void note_request(input logic [ADDR_W-1:0] addr);
			pfta_result_t want;
			int slot;
			want = '0;
			slot = -1;
			if ({1'b0, addr} >= limit) begin
				want.status = ST_OOB;
			end else begin
				want.page_number = addr[ADDR_W-1:OFFSET_W];
				want.byte_offset = addr[OFFSET_W-1:0];
				for (int i = 0; i < FRAMES; i++) begin
					if (slot < 0 && frame_used[i] && frame_page[i] == want.page_number)
						slot = i;
				end
				if (slot >= 0) begin
					want.status = ST_HIT;
					if (hit_count != COUNT_MAX)
						hit_count++;
				end else begin
					// A miss counts as a fault whether or not a frame is free.
					if (fault_count != COUNT_MAX)
						fault_count++;
					for (int i = 0; i < FRAMES; i++) begin
						if (slot < 0 && !frame_used[i]) begin
							frame_used[i] = 1'b1;
							frame_page[i] = want.page_number;
							slot = i;
						end
					end
					want.status = (slot >= 0) ? ST_LOAD : ST_FULL;
				end
				if (slot >= 0) begin
					want.frame_number = slot[FRAME_O_W-1:0];
					want.physical_address = {slot[FRAME_O_W-1:0], want.byte_offset};
				end
			end
			want.hit_total = hit_count;
			want.fault_total = fault_count;
			pending.push_back(want);
		endfunction

		function string show(input pfta_result_t r);
			return $sformatf("st=%0d pg=%0d off=%0d fr=%0d pa=%03h hits=%0d faults=%0d",
				r.status, r.page_number, r.byte_offset, r.frame_number,
				r.physical_address, r.hit_total, r.fault_total);
		endfunction

		function void log_failure(input string what);
			failures++;
			if (failures <= REPORT_LIMIT)
				$display("%0t: %s", $realtime, what);
		endfunction

		// Compare one transferred result with the oldest queued one.
		function void check_response(input pfta_result_t got);
			pfta_result_t want;
			if (pending.size() == 0) begin
				log_failure({"result with no request outstanding: ", show(got)});
			end else begin
				want = pending.pop_front();
				if (got !== want)
					log_failure({"mismatch: expected ", show(want), ", got ", show(got)});
			end
		endfunction

		// Anything still queued at the end never came out of the block.
		function void close_out();
			pfta_result_t want;
			while (pending.size() != 0) begin
				want = pending.pop_front();
				log_failure({"missing result, expected ", show(want)});
			end
		endfunction
	endclass

endpackage

// File: tb/page_frame_translate_alloc_test.sv
// Top-level testbench of the page frame translation block.
`timescale 1ns / 1ps

module page_frame_translate_alloc_test;
	import pfta_pkg::*;
	import pfta_check_pkg::*;

	localparam int HALF_PERIOD    = 6;
	localparam int RESET_CYCLES   = 9;
	localparam int SETTLE_CYCLES  = FRAMES + 6;
	localparam int HOLD_CYCLES    = 150;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int RANDOM_PHASES  = 8;
	localparam int PHASE_ITEMS    = 214;
	localparam int ADDR_MAX       = (1 << ADDR_W) - 1;

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	pfta_req_if req_bus ();
	pfta_rsp_if rsp_bus ();

	bit             calm;
	bit             hold_request;
	bit             hold_served;
	int unsigned    idle_cycles = 0;
	pfta_scoreboard sb = new();

	page_frame_translate_alloc u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_bus),
		.rsp     (rsp_bus),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	initial clk = 1'b0;
	always #HALF_PERIOD clk = ~clk;

	// Response side: random back-pressure, full-rate stretches and one long hold-off.
	initial begin : rsp_drive
		rsp_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request && !hold_served) begin
				hold_served = 1'b1;
				rsp_bus.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				rsp_bus.ready <= 1'b1;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				rsp_bus.ready <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
				rsp_bus.ready <= 1'b1;
			end else if (!calm && $urandom_range(0, 9) == 0) begin
				rsp_bus.ready <= 1'b1;
				repeat ($urandom_range(20, 80)) @(posedge clk);
			end else begin
				rsp_bus.ready <= 1'b1;
			end
		end
	end

	// Every result transfer is checked against the oldest prediction.
	always @(posedge clk) begin : rsp_monitor
		pfta_result_t got;
		if (arst_n && rsp_bus.valid && rsp_bus.ready) begin
			got.status = rsp_bus.status;
			got.page_number = rsp_bus.page_number;
			got.byte_offset = rsp_bus.byte_offset;
			got.frame_number = rsp_bus.frame_number;
			got.physical_address = rsp_bus.physical_address;
			got.hit_total = rsp_bus.hit_total;
			got.fault_total = rsp_bus.fault_total;
			sb.check_response(got);
		end
	end

	// Watchdog: ends the run after too many cycles without any transfer.
	always @(posedge clk) begin
		if (!arst_n || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("page_frame_translate_alloc regression: fail");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Offer one address and wait for its transfer, with an occasional gap first.
	task automatic send_address(input logic [ADDR_W-1:0] addr);
		if (!calm && $urandom_range(0, 4) == 0) begin
			req_bus.valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		req_bus.valid <= 1'b1;
		req_bus.vaddr <= addr;
		do @(posedge clk); while (!req_bus.ready);
		sb.note_request(addr);
	endtask

	// Let the block drain, then write the limit register with a setup and an access phase.
	task automatic write_limit(input logic [APB_DATA_W-1:0] value);
		req_bus.valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= REG_VIRTUAL_LIMIT;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_limit(value);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Mostly resident pages, some random addresses and some just around the limit.
	function automatic logic [ADDR_W-1:0] pick_address();
		int near;
		logic [OFF_O_W-1:0] offset;
		offset = OFF_O_W'($urandom);
		case ($urandom_range(0, 7))
			0, 1, 2, 3: pick_address = {sb.resident_page($urandom_range(0, FRAMES - 1)), offset};
			4, 5: pick_address = ADDR_W'($urandom);
			default: begin
				near = int'(sb.limit) - 2 + int'($urandom_range(0, 3));
				if (near < 0)
					near = 0;
				if (near > ADDR_MAX)
					near = ADDR_MAX;
				pick_address = near[ADDR_W-1:0];
			end
		endcase
	endfunction

	initial begin : stimulus
		logic [APB_DATA_W-1:0] limit_plan [RANDOM_PHASES];

		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		req_bus.valid <= 1'b0;
		req_bus.vaddr <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: loads into free frames, hits, a full table and the bounds check.
		send_address(16'h0000);
		send_address(16'h03FF);
		send_address(16'h1FFF);
		send_address(16'h2000);
		send_address(16'hFFFF);
		write_limit(32'h0001_0000);
		send_address(16'hFFFF);
		send_address(16'hAAAA);
		send_address(16'h5555);
		send_address(16'hFC00);
		send_address(16'h1C00);
		send_address(16'h0400);
		// A limit of zero rejects every address.
		write_limit(32'h0000_0000);
		send_address(16'h0000);
		send_address(16'hFFFF);
		write_limit(32'h0000_0001);
		send_address(16'h0000);
		send_address(16'h0001);
		// A limit above the address space accepts every address.
		write_limit(32'h0001_FFFF);
		send_address(16'hFFFF);
		// Bits above the register width are dropped.
		write_limit(32'hFFFE_0000);
		send_address(16'h0000);
		write_limit(32'h0000_FFFF);
		send_address(16'hFFFF);
		send_address(16'hFFFE);

		// Random phases, each under its own limit.
		limit_plan[0] = 32'h0000_0001;
		limit_plan[1] = 32'h0001_0000;
		limit_plan[2] = 32'h0000_2000;
		limit_plan[3] = $urandom;
		limit_plan[4] = 32'h0001_FFFF;
		limit_plan[5] = $urandom_range(1, 65536);
		limit_plan[6] = 32'h0000_0000;
		limit_plan[7] = $urandom_range(1024, 65535);
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			write_limit(limit_plan[p]);
			if (p == 2)
				hold_request = 1'b1;
			if (p == RANDOM_PHASES - 1)
				calm = 1'b1;
			for (int n = 0; n < PHASE_ITEMS; n++)
				send_address(pick_address());
		end

		// Drain and report.
		req_bus.valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		sb.close_out();
		if (sb.failures == 0) begin
			$display("page_frame_translate_alloc regression: pass");
		end else begin
			$display("page_frame_translate_alloc regression: fail");
		end
		$finish;
	end

endmodule

// File: files.f
hw/rtl/pfta_pkg.sv
hw/rtl/pfta_if.sv
hw/rtl/pfta_cell.sv
hw/rtl/pfta_regs.sv
hw/rtl/page_frame_translate_alloc.sv
tb/pfta_check_pkg.sv
tb/page_frame_translate_alloc_test.sv
